// ===== hw/rtl/sha_pkg.sv =====
// Package: SHA-256 constants, round function helpers and control types.
`default_nettype none
package sha_pkg;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenLimit   = 55;
  localparam logic [5:0]  DigestMax  = 6'd32;
  localparam logic [7:0]  PadByte    = 8'h80;
  localparam logic        KindData   = 1'b0;
  localparam logic        KindFinish = 1'b1;
  localparam logic [0:0]  RegDigestLen = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCHED,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    BLK_DATA,
    BLK_PAD_A,
    BLK_PAD_B
  } blk_kind_t;

  typedef struct packed {
    logic       we;
    logic [5:0] waddr;
    logic [7:0] wdata;
    logic [5:0] raddr;
  } store_ctl_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[t];
  endfunction

  function automatic logic [31:0] start_word(input logic [2:0] i);
    case (i)
      3'd0: return 32'h6a09e667;
      3'd1: return 32'hbb67ae85;
      3'd2: return 32'h3c6ef372;
      3'd3: return 32'ha54ff53a;
      3'd4: return 32'h510e527f;
      3'd5: return 32'h9b05688c;
      3'd6: return 32'h1f83d9ab;
      default: return 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/sha_if.sv =====
// Interfaces: byte input channel and digest output channel.
`default_nettype none
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

interface sha_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digest_byte;
  logic       is_last;
  modport source (output valid, digest_byte, is_last, input ready);
  modport sink (input valid, digest_byte, is_last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sha_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module sha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/sha_core.sv =====
// Compression engine: message schedule in a 16-word window, 64 rounds, chain update.
`default_nettype none
module sha_core import sha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        init,
  input  wire logic        load_en,
  input  wire logic [31:0] load_word,
  input  wire logic        start,
  output logic             done,
  input  wire logic [2:0]  chain_sel,
  output logic [31:0]      chain_word
);
  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] h [8];
  logic [5:0]  t;
  logic        busy;
  logic        fin;
  logic [31:0] s0, s1, wt, wn, t1, t2;

  assign wt = w[0];
  assign s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
  assign s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
  assign wn = w[0] + s0 + w[9] + s1;
  assign t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t) + wt;
  assign t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  assign chain_word = h[chain_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      t    <= '0;
      for (int i = 0; i < 8; i++) h[i] <= start_word(3'(i));
    end else begin
      done <= 1'b0;
      if (init) begin
        for (int i = 0; i < 8; i++) h[i] <= start_word(3'(i));
      end
      if (load_en) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= load_word;
      end
      if (start) begin
        busy <= 1'b1;
        t    <= '0;
        for (int i = 0; i < 8; i++) v[i] <= h[i];
      end else if (busy) begin
        v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
        v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= wn;
        t <= t + 6'd1;
        if (t == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |=> busy);
  assert property (@(posedge clk) disable iff (rst) done |-> !busy && !fin)
    else $error("done while busy");
  assert property (@(posedge clk) disable iff (rst) !(busy && fin))
    else $error("round and finish overlap");
endmodule
`default_nettype wire

// ===== hw/rtl/sha256_stream_hasher.sv =====
// Top level: SHA-256 stream hasher with byte store RAM, sequencer and APB register.
// Data byte: accepted while idle; the 64th byte of a block then holds off input for the
// byte load, the rounds and the chain update of the compression engine.
// Finish: one or two padded blocks, then one digest byte per cycle while the sink
// takes them.
// Synchronous active-high reset restores the initial hash, zero count, digest_len 32.
`default_nettype none
module sha256_stream_hasher import sha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  sha_in_if.sink           in_ch,
  sha_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  state_t      state, state_next;
  blk_kind_t   blk;
  logic [5:0]  digest_len;
  logic [6:0]  fill_count;
  logic [63:0] byte_total;
  logic [6:0]  cnt;
  logic [5:0]  emit_i, emit_k;
  logic [7:0]  rbyte;
  logic [23:0] wacc;
  logic        two_blocks;
  store_ctl_t  sc;
  logic        core_init, core_load, core_start, core_done;
  logic [31:0] load_word, chain_word;
  logic [7:0]  pbyte;
  logic [5:0]  byte_idx;
  logic [63:0] bits;
  logic        rd_valid;

  assign pready = 1'b1;
  assign prdata = {26'd0, digest_len};
  assign bits   = {byte_total[60:0], 3'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      digest_len <= DigestMax;
    end else if (psel && penable && pwrite && paddr == {RegDigestLen, 1'b0}) begin
      digest_len <= pwdata[5:0];
    end
  end

  sha_ram #(.Width(8), .Depth(BlockBytes)) u_store (
    .clk(clk), .we(sc.we), .waddr(sc.waddr), .wdata(sc.wdata),
    .raddr(sc.raddr), .rdata(rbyte)
  );

  sha_core u_core (
    .clk(clk), .rst(rst), .init(core_init), .load_en(core_load), .load_word(load_word),
    .start(core_start), .done(core_done), .chain_sel(emit_i[4:2]), .chain_word(chain_word)
  );

  // byte delivered to the schedule: previous read (cnt-1)
  assign byte_idx = 6'(cnt - 7'd1);
  always_comb begin
    pbyte = 8'h00;
    case (blk)
      BLK_DATA: pbyte = rbyte;
      BLK_PAD_A: begin
        if ({1'b0, byte_idx} < fill_count) pbyte = rbyte;
        else if ({1'b0, byte_idx} == fill_count) pbyte = PadByte;
        else if (!two_blocks && byte_idx >= 6'd56) pbyte = bits[8*(63-byte_idx) +: 8];
      end
      BLK_PAD_B: begin
        if (byte_idx >= 6'd56) pbyte = bits[8*(63-byte_idx) +: 8];
      end
      default: pbyte = 8'h00;
    endcase
  end
  assign load_word = {wacc, pbyte};
  assign rd_valid  = (state == ST_LOAD) && (cnt != 7'd0);
  assign core_load = rd_valid && (byte_idx[1:0] == 2'd3);

  always_ff @(posedge clk) begin
    if (rd_valid) wacc <= {wacc[15:0], pbyte};
  end

  always_comb begin
    state_next   = state;
    in_ch.ready  = 1'b0;
    sc           = '0;
    sc.waddr     = fill_count[5:0];
    sc.wdata     = in_ch.data_byte;
    sc.raddr     = cnt[5:0];
    core_start   = 1'b0;
    core_init    = 1'b0;
    out_ch.valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.kind == KindData) begin
            sc.we = 1'b1;
            if (fill_count == 7'(BlockBytes - 1)) state_next = ST_LOAD;
          end else begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_LOAD: if (cnt == 7'd64) begin
        core_start = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: if (core_done) begin
        if (blk == BLK_DATA) state_next = ST_IDLE;
        else if (blk == BLK_PAD_A && two_blocks) state_next = ST_LOAD;
        else state_next = ST_EMIT;
      end
      ST_EMIT: begin
        out_ch.valid = (emit_k != 6'd0);
        if (emit_k == 6'd0 || (out_ch.ready && emit_i == 6'(emit_k - 6'd1))) begin
          core_init  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_ch.digest_byte = chain_word[8*(3-emit_i[1:0]) +: 8];
  assign out_ch.is_last     = (emit_i == 6'(emit_k - 6'd1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      byte_total <= '0;
      cnt        <= '0;
      emit_i     <= '0;
      emit_k     <= '0;
      blk        <= BLK_DATA;
      two_blocks <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (in_ch.valid) begin
          cnt <= '0;
          if (in_ch.kind == KindData) begin
            byte_total <= byte_total + 64'd1;
            fill_count <= fill_count + 7'd1;
            blk        <= BLK_DATA;
          end else begin
            blk        <= BLK_PAD_A;
            two_blocks <= fill_count > 7'(LenLimit);
            emit_k     <= (digest_len > DigestMax) ? DigestMax : digest_len;
            emit_i     <= '0;
          end
        end
        ST_LOAD: cnt <= cnt + 7'd1;
        ST_ROUND: if (core_done) begin
          cnt <= '0;
          if (blk == BLK_DATA) fill_count <= '0;
          else if (blk == BLK_PAD_A && two_blocks) blk <= BLK_PAD_B;
        end
        ST_EMIT: begin
          if (out_ch.ready && emit_k != 6'd0) emit_i <= emit_i + 6'd1;
          if (state_next == ST_IDLE) begin
            fill_count <= '0;
            byte_total <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_ch.ready |-> state == ST_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (rst) fill_count <= 7'd64)
    else $error("fill count overflow");
  assert property (@(posedge clk) disable iff (rst) out_ch.valid |-> emit_i < emit_k)
    else $error("emit index past length");
endmodule
`default_nettype wire
